### hw/rtl/assert_macros.svh
// assertion macros used by the button gesture detector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define BGD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// checked on every rising edge, reset included
`define BGD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: assertion failed");

`endif

### hw/rtl/bgd_pkg.sv
// types and constants for the button gesture detector
package bgd_pkg;

  // time counter width
  localparam int unsigned TimeBits = 24;

  // field widths
  localparam int unsigned CfgTimeW = 24;
  localparam int unsigned DeltaW   = 16;
  localparam int unsigned TapsW    = 8;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned GestW    = 2;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 8;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegMode      = 3'd0;
  localparam logic [CfgAddrW-1:0] RegHoldThr   = 3'd1;
  localparam logic [CfgAddrW-1:0] RegFireOnce  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegPressLim  = 3'd3;
  localparam logic [CfgAddrW-1:0] RegGapLim    = 3'd4;
  localparam logic [CfgAddrW-1:0] RegTapsNeed  = 3'd5;

  // gesture modes
  localparam logic [ModeW-1:0] ModeDown     = 3'd0;
  localparam logic [ModeW-1:0] ModeClick    = 3'd1;
  localparam logic [ModeW-1:0] ModeRelease  = 3'd2;
  localparam logic [ModeW-1:0] ModeClickRel = 3'd3;
  localparam logic [ModeW-1:0] ModeHold     = 3'd4;
  localparam logic [ModeW-1:0] ModeMultiTap = 3'd5;

  // gesture states
  localparam logic [GestW-1:0] GestNone      = 2'd0;
  localparam logic [GestW-1:0] GestOngoing   = 2'd1;
  localparam logic [GestW-1:0] GestTriggered = 2'd2;

  // configuration as seen by the evaluation logic
  typedef struct packed {
    logic [ModeW-1:0]    mode;
    logic [CfgTimeW-1:0] hold_threshold;
    logic                fire_once;
    logic [CfgTimeW-1:0] tap_press_limit;
    logic [CfgTimeW-1:0] tap_gap_limit;
    logic [TapsW-1:0]    taps_needed;
  } bgd_cfg_t;

endpackage

### hw/rtl/bgd_cfg_regs.sv
// configuration register file of the button gesture detector
module bgd_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [bgd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bgd_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bgd_pkg::bgd_cfg_t            cfg_o
);
  import bgd_pkg::*;

  bgd_cfg_t cfg_q, cfg_d;

  // decode one write transaction; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        RegMode:     cfg_d.mode            = cfg_wdata_i[ModeW-1:0];
        RegHoldThr:  cfg_d.hold_threshold  = cfg_wdata_i[CfgTimeW-1:0];
        RegFireOnce: cfg_d.fire_once       = cfg_wdata_i[0];
        RegPressLim: cfg_d.tap_press_limit = cfg_wdata_i[CfgTimeW-1:0];
        RegGapLim:   cfg_d.tap_gap_limit   = cfg_wdata_i[CfgTimeW-1:0];
        RegTapsNeed: cfg_d.taps_needed     = cfg_wdata_i[TapsW-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  // register storage with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode            <= ModeDown;
      cfg_q.hold_threshold  <= CfgTimeW'(500);
      cfg_q.fire_once       <= 1'b1;
      cfg_q.tap_press_limit <= CfgTimeW'(200);
      cfg_q.tap_gap_limit   <= CfgTimeW'(200);
      cfg_q.taps_needed     <= TapsW'(2);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/bgd_eval.sv
// gesture evaluation: per-sample state and result logic
`include "assert_macros.svh"

module bgd_eval (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       pressed_i,
  input  logic [bgd_pkg::DeltaW-1:0] delta_i,
  input  bgd_pkg::bgd_cfg_t          cfg_i,
  output logic [bgd_pkg::GestW-1:0]  gesture_o
);
  import bgd_pkg::*;

  localparam int unsigned SumW = ((TimeBits > DeltaW) ? TimeBits : DeltaW) + 1;
  localparam int unsigned CmpW = (TimeBits > CfgTimeW) ? TimeBits : CfgTimeW;
  localparam logic [TimeBits-1:0] TimeMax = '1;
  localparam logic [TapsW-1:0]    TapsMax = '1;

  // tap phase codes
  localparam logic [1:0] TapIdle = 2'd0;
  localparam logic [1:0] TapRel  = 2'd1;
  localparam logic [1:0] TapGap  = 2'd2;

  function automatic logic [TimeBits-1:0] sat_add(input logic [TimeBits-1:0] a,
                                                  input logic [DeltaW-1:0]   b);
    logic [SumW-1:0] s;
    s = SumW'(a) + SumW'(b);
    if (s > SumW'(TimeMax)) return TimeMax;
    return s[TimeBits-1:0];
  endfunction

  logic                prev_q;
  logic [TimeBits-1:0] held_q, held_d;
  logic                fired_q, fired_d;
  logic [1:0]          phase_q, phase_d;
  logic [TimeBits-1:0] pticks_q, pticks_d;
  logic [TapsW-1:0]    taps_q, taps_d;

  logic                rise, fall;
  logic [TimeBits-1:0] phase_sum;
  logic [TapsW-1:0]    taps_inc;
  logic [GestW-1:0]    hold_res, tap_res;

  assign rise = pressed_i & ~prev_q;
  assign fall = ~pressed_i & prev_q;

  // hold: saturating pressed time against the threshold
  always_comb begin
    held_d   = pressed_i ? sat_add(held_q, delta_i) : '0;
    fired_d  = (CmpW'(held_d) >= CmpW'(cfg_i.hold_threshold));
    hold_res = (fired_d && (!fired_q || !cfg_i.fire_once)) ? GestTriggered : GestNone;
  end

  // multi tap phase sequencer
  assign phase_sum = sat_add(pticks_q, delta_i);
  assign taps_inc  = (taps_q == TapsMax) ? taps_q : taps_q + TapsW'(1);

  always_comb begin
    phase_d  = phase_q;
    pticks_d = pticks_q;
    taps_d   = taps_q;
    tap_res  = GestNone;
    unique case (phase_q)
      TapRel: begin
        pticks_d = phase_sum;
        if (pressed_i) begin
          tap_res = GestOngoing;
        end else if (CmpW'(phase_sum) <= CmpW'(cfg_i.tap_press_limit)) begin
          taps_d = taps_inc;
          if (taps_inc >= cfg_i.taps_needed) begin
            phase_d  = TapIdle;
            pticks_d = '0;
            taps_d   = '0;
            tap_res  = GestTriggered;
          end else begin
            phase_d  = TapGap;
            pticks_d = '0;
            tap_res  = GestOngoing;
          end
        end else begin
          phase_d  = TapIdle;
          pticks_d = '0;
          taps_d   = '0;
        end
      end
      TapGap: begin
        pticks_d = phase_sum;
        if (!pressed_i) begin
          tap_res = GestOngoing;
        end else if (CmpW'(phase_sum) <= CmpW'(cfg_i.tap_gap_limit)) begin
          phase_d  = TapRel;
          pticks_d = '0;
          tap_res  = GestOngoing;
        end else begin
          phase_d  = TapIdle;
          pticks_d = '0;
          taps_d   = '0;
        end
      end
      default: begin
        // idle, and the unused phase code behaves as idle
        if (pressed_i) begin
          phase_d  = TapRel;
          pticks_d = '0;
          tap_res  = GestOngoing;
        end
      end
    endcase
  end

  // result select by mode
  always_comb begin
    unique case (cfg_i.mode)
      ModeDown:     gesture_o = pressed_i ? GestTriggered : GestNone;
      ModeClick:    gesture_o = rise ? GestTriggered : GestNone;
      ModeRelease:  gesture_o = pressed_i ? GestOngoing : (fall ? GestTriggered : GestNone);
      ModeClickRel: gesture_o = rise ? GestTriggered :
                                (pressed_i ? GestOngoing : (fall ? GestTriggered : GestNone));
      ModeHold:     gesture_o = hold_res;
      ModeMultiTap: gesture_o = tap_res;
      default:      gesture_o = GestNone;
    endcase
  end

  // state update, one sample per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      held_q   <= '0;
      fired_q  <= 1'b0;
      phase_q  <= TapIdle;
      pticks_q <= '0;
      taps_q   <= '0;
    end else if (step_i) begin
      prev_q <= pressed_i;
      if (cfg_i.mode == ModeHold) begin
        held_q  <= held_d;
        fired_q <= fired_d;
      end
      if (cfg_i.mode == ModeMultiTap) begin
        phase_q  <= phase_d;
        pticks_q <= pticks_d;
        taps_q   <= taps_d;
      end
    end
  end

  // idle phase always carries a cleared tap sequence
  `BGD_ASSERT(a_idle_clear, (phase_q == TapIdle) |-> (pticks_q == '0 && taps_q == '0))
  // waiting for the next press means at least one tap was counted
  `BGD_ASSERT(a_gap_has_tap, (phase_q == TapGap) |-> (taps_q != '0))
  // a one-shot hold trigger leaves the fired flag set
  `BGD_ASSERT(a_hold_once,
    (step_i && cfg_i.mode == ModeHold && cfg_i.fire_once && gesture_o == GestTriggered)
      |=> fired_q)

endmodule

### hw/rtl/button_gesture_detector_unit.sv
// top level of the button gesture detector with stream and config ports
//
//  channel    | direction | handshake                    | payload
//  s_axis     | in        | s_axis_tvalid/s_axis_tready  | pressed, delta_ticks
//  m_axis     | out       | m_axis_tvalid/m_axis_tready  | gesture_state
//  cfg        | in        | cfg_valid_i/cfg_ready_o      | register index, data
//
// one sample per cycle sustained while the output is not stalled, set by the single
// evaluation stage; each input sample is evaluated into the result register and offered
// rst_ni clears all gesture state and loads the register reset values
// a stalled output holds its result and stops evaluation; the input register takes a sample
// while it is empty or its sample moves on, so up to two samples wait inside the block
// configuration writes take effect in the cycle after they are offered and are always ready
module button_gesture_detector_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [bgd_pkg::InDataW-1:0]  s_axis_tdata,  // [0] pressed, [16:1] delta_ticks
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [bgd_pkg::OutDataW-1:0] m_axis_tdata,  // [1:0] gesture_state
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bgd_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [bgd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import bgd_pkg::*;

  bgd_cfg_t          cfg;
  logic              in_valid_q;
  logic              in_pressed_q;
  logic [DeltaW-1:0] in_delta_q;
  logic              out_valid_q;
  logic [GestW-1:0]  out_gest_q;
  logic [GestW-1:0]  gest;
  logic              step;
  logic              in_take;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  bgd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // pipeline flow control
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_pressed_q <= s_axis_tdata[0];
      in_delta_q   <= s_axis_tdata[DeltaW:1];
    end
  end

  // gesture evaluation
  bgd_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .pressed_i(in_pressed_q),
    .delta_i  (in_delta_q),
    .cfg_i    (cfg),
    .gesture_o(gest)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_gest_q <= gest;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_gest_q);

endmodule
